// ===== rtl/core/smoe_pkg.sv =====
`default_nettype none
package smoe_pkg;

  // opcodes
  localparam logic [5:0] OP_PUSH  = 6'd0;
  localparam logic [5:0] OP_PLUS  = 6'd1;
  localparam logic [5:0] OP_MINUS = 6'd2;
  localparam logic [5:0] OP_EQ    = 6'd3;
  localparam logic [5:0] OP_NE    = 6'd4;
  localparam logic [5:0] OP_GT    = 6'd5;
  localparam logic [5:0] OP_LT    = 6'd6;
  localparam logic [5:0] OP_GE    = 6'd7;
  localparam logic [5:0] OP_LE    = 6'd8;
  localparam logic [5:0] OP_IF    = 6'd9;
  localparam logic [5:0] OP_ELSE  = 6'd10;
  localparam logic [5:0] OP_END   = 6'd11;
  localparam logic [5:0] OP_PRINT = 6'd12;
  localparam logic [5:0] OP_DUP   = 6'd13;
  localparam logic [5:0] OP_DUP2  = 6'd14;
  localparam logic [5:0] OP_SWAP  = 6'd15;
  localparam logic [5:0] OP_DROP  = 6'd16;
  localparam logic [5:0] OP_WHILE = 6'd17;
  localparam logic [5:0] OP_DO    = 6'd18;
  localparam logic [5:0] OP_MEM   = 6'd19;
  localparam logic [5:0] OP_LOAD  = 6'd20;
  localparam logic [5:0] OP_STORE = 6'd21;
  localparam logic [5:0] OP_SYS3  = 6'd24;
  localparam logic [5:0] OP_SHR   = 6'd28;
  localparam logic [5:0] OP_SHL   = 6'd29;
  localparam logic [5:0] OP_OR    = 6'd30;
  localparam logic [5:0] OP_AND   = 6'd31;
  localparam logic [5:0] OP_OVER  = 6'd32;
  localparam logic [5:0] OP_MOD   = 6'd33;

  // fault codes
  localparam logic [2:0] F_NONE    = 3'd0;
  localparam logic [2:0] F_UNDER   = 3'd1;
  localparam logic [2:0] F_OVER    = 3'd2;
  localparam logic [2:0] F_ADDR    = 3'd3;
  localparam logic [2:0] F_UNIMPL  = 3'd4;
  localparam logic [2:0] F_SYSNUM  = 3'd5;
  localparam logic [2:0] F_FD      = 3'd6;
  localparam logic [2:0] F_MODZERO = 3'd7;

  function automatic logic [2:0] pop_count(input logic [5:0] op);
    case (op)
      OP_PUSH, OP_ELSE, OP_END, OP_WHILE, OP_MEM: pop_count = 3'd0;
      OP_IF, OP_PRINT, OP_DUP, OP_DROP, OP_DO, OP_LOAD: pop_count = 3'd1;
      OP_SYS3: pop_count = 3'd4;
      default: pop_count = 3'd2;
    endcase
  endfunction

  function automatic logic [2:0] push_count(input logic [5:0] op);
    case (op)
      OP_IF, OP_ELSE, OP_END, OP_DROP, OP_WHILE, OP_DO, OP_STORE, OP_SYS3:
        push_count = 3'd0;
      OP_DUP, OP_SWAP: push_count = 3'd2;
      OP_DUP2: push_count = 3'd4;
      OP_OVER: push_count = 3'd3;
      default: push_count = 3'd1;
    endcase
  endfunction

  function automatic logic is_unimpl(input logic [5:0] op);
    is_unimpl = (op > OP_MOD) || (op == 6'd22) || (op == 6'd23) ||
                (op >= 6'd25 && op <= 6'd27);
  endfunction

  // controller -> datapath commands
  typedef struct packed {
    logic       latch;     // capture input item
    logic       rd_issue;  // issue stack read k
    logic [1:0] rd_k;
    logic       rd_take;   // capture stack read data k (issued previous cycle)
    logic [1:0] take_k;
    logic       mem_rd;    // issue byte read
    logic       mem_take;
    logic       div_start;
    logic       wr_issue;  // write one stack entry k
    logic [1:0] wr_k;
    logic       commit;    // final count / memory store / result capture
  } smoe_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic       mem_clear; // byte memory clearing sweep running
    logic       past_end;
    logic       early_fault;
    logic [2:0] pops;
    logic [2:0] pushes;
    logic       need_mem;
    logic       need_div;
    logic       div_done;
    logic       late_fault;
  } smoe_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/smoe_ram.sv =====
`default_nettype none
module smoe_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/smoe_mod.sv =====
`default_nettype none
// Signed remainder, one quotient bit per cycle on magnitudes.
module smoe_mod (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic      [63:0] rem
);
  logic [63:0] dvd, dvs, r;
  logic        neg, busy;
  logic [6:0]  cnt;
  logic [64:0] trial;

  always_comb trial = {r, dvd[63]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        r    <= '0;
        dvd  <= a[63] ? 64'd0 - a : a;
        dvs  <= b[63] ? 64'd0 - b : b;
        neg  <= a[63];
      end else if (busy) begin
        if (trial[64]) r <= {r[62:0], dvd[63]};
        else r <= trial[63:0];
        dvd <= {dvd[62:0], 1'b0};
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = neg ? 64'd0 - r : r;
endmodule
`default_nettype wire

// ===== rtl/core/smoe_ctrl.sv =====
`default_nettype none
module smoe_ctrl
  import smoe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       out_busy,
  input  wire smoe_stat_t st,
  output smoe_cmd_t       cmd
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_READ  = 7'b0000100,
    S_MEM   = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [2:0] k, k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  // no request taken while the byte memory is being cleared
  assign in_ready = (state == S_IDLE) && !st.mem_clear;

  always_comb begin
    state_next = state;
    k_next     = k;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && !st.mem_clear) begin
          cmd.latch  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        k_next = '0;
        if (st.past_end || st.early_fault) state_next = S_DONE;
        else if (st.pops != 3'd0) begin
          cmd.rd_issue = 1'b1;
          cmd.rd_k     = 2'd0;
          k_next       = 3'd1;
          state_next   = S_READ;
        end else state_next = S_WRITE;
      end
      // issue read k while capturing read k-1
      S_READ: begin
        cmd.rd_take = 1'b1;
        cmd.take_k  = 2'(k - 3'd1);
        if (k < st.pops) begin
          cmd.rd_issue = 1'b1;
          cmd.rd_k     = k[1:0];
          k_next       = k + 3'd1;
        end else begin
          k_next = '0;
          if (st.need_mem) begin
            state_next = S_MEM;
          end else if (st.need_div) begin
            state_next = S_DIV;
          end else state_next = S_WRITE;
        end
      end
      // k=0: address check and read issue, k=1: capture
      S_MEM: begin
        if (k == 3'd0) begin
          if (st.late_fault) state_next = S_DONE;
          else begin
            cmd.mem_rd = 1'b1;
            k_next     = 3'd1;
          end
        end else begin
          cmd.mem_take = 1'b1;
          k_next       = '0;
          state_next   = S_WRITE;
        end
      end
      S_DIV: begin
        if (k == 3'd0) begin
          if (st.late_fault) state_next = S_DONE;
          else begin
            cmd.div_start = 1'b1;
            k_next        = 3'd1;
          end
        end else if (st.div_done) begin
          k_next     = '0;
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (st.late_fault) state_next = S_DONE;
        else if (k < st.pushes) begin
          cmd.wr_issue = 1'b1;
          cmd.wr_k     = k[1:0];
          k_next       = k + 3'd1;
        end else state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/smoe_dp.sv =====
`default_nettype none
module smoe_dp
  import smoe_pkg::*;
#(
  parameter int StackDepth   = 256,
  parameter int MemBytes     = 65536,
  parameter int ProgramDepth = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_wdata,
  input  wire logic [5:0]  cmd_in,
  input  wire logic [63:0] operand,
  input  wire logic [15:0] current_index,
  input  wire smoe_cmd_t   cmd,
  output smoe_stat_t       st,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [16:0]      next_index,
  output logic             halted,
  output logic             print_valid,
  output logic [63:0]      print_value,
  output logic             write_valid,
  output logic             write_to_stderr,
  output logic [15:0]      write_addr,
  output logic [16:0]      write_count,
  output logic [2:0]       fault,
  output logic [$clog2(StackDepth+1)-1:0] count
);
  localparam int SAW = $clog2(StackDepth);
  localparam int CW  = $clog2(StackDepth + 1);
  localparam int MAW = $clog2(MemBytes);
  localparam logic [64:0] MemLim = 65'(MemBytes);
  localparam logic [16:0] ProgLim = (ProgramDepth > 65536) ? 17'h10000 : 17'(ProgramDepth);

  logic [16:0] plen, eff;
  logic [5:0]  op;
  logic [63:0] opnd;
  logic [15:0] cur;
  logic [63:0] t [4];
  logic [63:0] res [4];
  logic [7:0]  mem_byte;
  logic [63:0] mod_rem;
  logic        mod_done;
  logic [2:0]  early_code, late_code, fault_c;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) plen <= '0;
    else if (cfg_we) plen <= cfg_wdata;
  end
  assign eff = (plen < ProgLim) ? plen : ProgLim;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op   <= cmd_in;
      opnd <= operand;
      cur  <= current_index;
    end
  end

  // stack memory
  logic           s_we;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [63:0]    s_rdata;
  logic [CW-1:0]  base;

  assign base    = count - CW'(st.pops);
  assign s_raddr = SAW'(count - CW'(1) - CW'(cmd.rd_k));
  assign s_we    = cmd.wr_issue;
  assign s_waddr = SAW'(base + CW'(cmd.wr_k));

  smoe_ram #(.Width(64), .Depth(StackDepth)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(res[cmd.wr_k]),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      t[0] <= '0; t[1] <= '0; t[2] <= '0; t[3] <= '0;
    end else if (cmd.rd_take) t[cmd.take_k] <= s_rdata;
  end

  // byte memory, with a clearing sweep after reset
  logic           clr_busy;
  logic [MAW:0]   clr_addr;
  logic           m_we;
  logic [MAW-1:0] m_waddr, m_raddr;
  logic [7:0]     m_wdata, m_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + (MAW+1)'(1);
      if (clr_addr == (MAW+1)'(MemBytes - 1)) clr_busy <= 1'b0;
    end
  end

  logic do_store;
  assign do_store = cmd.commit && (fault_c == F_NONE) && !st.past_end && (op == OP_STORE);
  assign m_we    = clr_busy || do_store;
  assign m_waddr = clr_busy ? clr_addr[MAW-1:0] : t[1][MAW-1:0];
  assign m_wdata = clr_busy ? 8'd0 : t[0][7:0];
  assign m_raddr = t[0][MAW-1:0];

  smoe_ram #(.Width(8), .Depth(MemBytes)) u_mem (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.mem_take) mem_byte <= m_rdata;
  end

  smoe_mod u_mod (
    .clk(clk), .rst(rst), .start(cmd.div_start), .a(t[1]), .b(t[0]),
    .done(mod_done), .rem(mod_rem)
  );

  // status
  logic [CW:0] after;
  assign after = (CW+1)'(count) - (CW+1)'(st.pops) + (CW+1)'(st.pushes);
  assign st.mem_clear = clr_busy;
  assign st.pops      = pop_count(op);
  assign st.pushes    = push_count(op);
  assign st.past_end  = ({1'b0, cur} >= eff);
  assign st.need_mem  = (op == OP_LOAD);
  assign st.need_div  = (op == OP_MOD);
  assign st.div_done  = mod_done;

  always_comb begin
    if (is_unimpl(op)) early_code = F_UNIMPL;
    else if (CW'(st.pops) > count) early_code = F_UNDER;
    else if (after > (CW+1)'(StackDepth)) early_code = F_OVER;
    else early_code = F_NONE;
  end
  assign st.early_fault = (early_code != F_NONE);

  always_comb begin
    late_code = F_NONE;
    case (op)
      OP_LOAD:  if ({1'b0, t[0]} >= MemLim) late_code = F_ADDR;
      OP_STORE: if ({1'b0, t[1]} >= MemLim) late_code = F_ADDR;
      OP_MOD:   if (t[0] == 64'd0) late_code = F_MODZERO;
      OP_SYS3: begin
        if (t[0] != 64'd1) late_code = F_SYSNUM;
        else if (t[1] != 64'd1 && t[1] != 64'd2) late_code = F_FD;
        else if ({1'b0, t[2]} >= MemLim ||
                 {1'b0, t[3]} > MemLim - {1'b0, t[2]}) late_code = F_ADDR;
      end
      default: late_code = F_NONE;
    endcase
  end
  assign st.late_fault = (late_code != F_NONE);
  assign fault_c = st.early_fault ? early_code : late_code;

  // results to push, from t[] (b = t0, a = t1)
  logic [63:0] a, b;
  logic        lt_ab, lt_ba;
  assign b = t[0];
  assign a = t[1];
  assign lt_ab = $signed(a) < $signed(b);
  assign lt_ba = $signed(b) < $signed(a);

  always_comb begin
    res[0] = '0; res[1] = '0; res[2] = '0; res[3] = '0;
    case (op)
      OP_PUSH:  res[0] = opnd;
      OP_PLUS:  res[0] = a + b;
      OP_MINUS: res[0] = a - b;
      OP_EQ:    res[0] = {63'd0, a == b};
      OP_NE:    res[0] = {63'd0, a != b};
      OP_GT:    res[0] = {63'd0, lt_ba};
      OP_LT:    res[0] = {63'd0, lt_ab};
      OP_GE:    res[0] = {63'd0, !lt_ab};
      OP_LE:    res[0] = {63'd0, !lt_ba};
      OP_PRINT: res[0] = b;
      OP_DUP:   begin res[0] = b; res[1] = b; end
      OP_DUP2:  begin res[0] = a; res[1] = b; res[2] = a; res[3] = b; end
      OP_SWAP:  begin res[0] = b; res[1] = a; end
      OP_LOAD:  res[0] = {56'd0, mem_byte};
      OP_SHR:   res[0] = 64'($signed(a) >>> b[5:0]);
      OP_SHL:   res[0] = a << b[5:0];
      OP_OR:    res[0] = a | b;
      OP_AND:   res[0] = a & b;
      OP_OVER:  begin res[0] = a; res[1] = b; res[2] = a; end
      OP_MOD:   res[0] = (b == '1) ? 64'd0 : mod_rem;
      default:  res[0] = '0;
    endcase
  end

  // next index
  logic [64:0] nxt;
  always_comb begin
    nxt = {49'd0, cur} + 65'd1;
    case (op)
      OP_IF, OP_DO: if (b == 64'd0) nxt = {1'b0, opnd};
      OP_ELSE, OP_END: nxt = {1'b0, opnd};
      default: nxt = nxt;
    endcase
  end

  // stack count
  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (cmd.commit && !st.past_end && fault_c == F_NONE) count <= CW'(after);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (cmd.commit) res_valid <= 1'b1;
    else if (res_ready) res_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      print_valid <= 1'b0; print_value <= '0;
      write_valid <= 1'b0; write_to_stderr <= 1'b0;
      write_addr <= '0; write_count <= '0; fault <= F_NONE;
      if (st.past_end) begin
        next_index <= eff; halted <= 1'b1;
      end else if (fault_c != F_NONE) begin
        next_index <= {1'b0, cur}; halted <= 1'b1; fault <= fault_c;
      end else begin
        if (nxt >= {48'd0, eff}) begin
          next_index <= eff; halted <= 1'b1;
        end else begin
          next_index <= nxt[16:0]; halted <= 1'b0;
        end
        if (op == OP_PRINT) begin
          print_valid <= 1'b1; print_value <= b;
        end
        if (op == OP_SYS3) begin
          write_valid <= 1'b1; write_to_stderr <= (t[1] == 64'd2);
          write_addr <= t[2][15:0]; write_count <= t[3][16:0];
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/stack_machine_op_executor_core.sv =====
`default_nettype none
// Stack machine instruction executor.
// Input channel (in_valid/in_ready): one fetched instruction per request:
// cmd, operand, current_index. Output channel (out_valid/out_ready): one
// result per instruction: next_index, halted, print and write-request fields
// and a fault code. program_length is written through cfg_we/cfg_wdata.
// Steps: latch, check, stack reads of the pops, a byte memory port read for
// load or the bit-serial remainder unit for modulo, stack writes of the
// pushes, result register. Past-end and stack faults skip to the result.
// One instruction is in flight at a time; the next request is taken the
// cycle after the result is registered. The stack RAM has one read and one
// write port, used one entry per cycle.
// Reset clears the stack count and program length and starts a clearing
// sweep that zeroes every byte of the byte memory; no request is accepted
// during the sweep.
// A stalled receiver holds the result in the output register; the next
// instruction is accepted but not finished until the result is taken.
module stack_machine_op_executor_core
  import smoe_pkg::*;
#(
  parameter int STACK_DEPTH   = 256,
  parameter int MEM_BYTES     = 65536,
  parameter int PROGRAM_DEPTH = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [5:0]  cmd,
  input  wire logic [63:0] operand,
  input  wire logic [15:0] current_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [16:0]      next_index,
  output logic             halted,
  output logic             print_valid,
  output logic [63:0]      print_value,
  output logic             write_valid,
  output logic             write_to_stderr,
  output logic [15:0]      write_addr,
  output logic [16:0]      write_count,
  output logic [2:0]       fault
);
  smoe_cmd_t  c;
  smoe_stat_t s;
  logic [$clog2(STACK_DEPTH+1)-1:0] count;

  smoe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_busy(out_valid && !out_ready), .st(s), .cmd(c)
  );

  smoe_dp #(
    .StackDepth(STACK_DEPTH), .MemBytes(MEM_BYTES), .ProgramDepth(PROGRAM_DEPTH)
  ) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .cmd_in(cmd), .operand(operand), .current_index(current_index),
    .cmd(c), .st(s), .res_valid(out_valid), .res_ready(out_ready),
    .next_index(next_index), .halted(halted), .print_valid(print_valid),
    .print_value(print_value), .write_valid(write_valid),
    .write_to_stderr(write_to_stderr), .write_addr(write_addr),
    .write_count(write_count), .fault(fault), .count(count)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= ($clog2(STACK_DEPTH+1))'(STACK_DEPTH)) else $error("stack count overflow");
  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault != F_NONE |-> halted && !print_valid && !write_valid)
    else $error("fault without halt");
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    c.commit |-> !(out_valid && !out_ready)) else $error("result overwritten");
endmodule
`default_nettype wire
